// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk_i with reset rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TSCM_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define TSCM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/tscm_pkg.sv
// ----------------------------------------------------------------------------
// tscm_pkg
// shared types and constants of the three-sum counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tscm_pkg;

  localparam int TSCM_MAX_ITEMS  = 1024;
  localparam int TSCM_VALUE_BITS = 8;
  localparam int TARGET_W        = 10;
  localparam int COUNT_W         = 30;
  localparam logic [COUNT_W-1:0] COUNT_MOD = 30'd1000000007;

  typedef struct packed {
    logic ins;
    logic shf;
  } tscm_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_A_RD,
    ST_A_WT,
    ST_P_RD,
    ST_P_EV,
    ST_RL_RD,
    ST_RL_EV,
    ST_RH_RD,
    ST_RH_EV,
    ST_MUL,
    ST_RED,
    ST_ADD,
    ST_NEXT_A,
    ST_OUT
  } tscm_state_e;

endpackage

`default_nettype wire

// File: design/three_sum_count_with_multiplicity_core.sv
// ----------------------------------------------------------------------------
// three_sum_count_with_multiplicity_core
// counts index triples whose values sum to the target, modulo 1e9+7
// ----------------------------------------------------------------------------
// Values are taken one per cycle while busy is low and kept sorted in a row of
// cells as they arrive. On the transaction marked last the block goes busy,
// shifts the n sorted values into a memory and runs the two-pointer walk over
// it: a read and an evaluate state per pointer move or run scan step, multiply,
// reduce and add states per counted run, and read, wait and next states per
// first element; the single memory with its registered read sets the step
// time. The result is on triple_count_o and overflow_o from the one cycle in
// which done_o is high until the next result; done_o cannot be held.
`timescale 1ns / 1ps
`default_nettype none

module three_sum_count_with_multiplicity_core
  import tscm_pkg::*;
#(
  parameter int MAX_ITEMS  = TSCM_MAX_ITEMS,
  parameter int VALUE_BITS = TSCM_VALUE_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [VALUE_BITS-1:0] value_i,
  input  wire logic                  last_i,
  input  wire logic                  target_sum_we_i,
  input  wire logic [TARGET_W-1:0]   target_sum_i,
  output logic                       done_o,
  output logic [COUNT_W-1:0]         triple_count_o,
  output logic                       overflow_o
);

  localparam int IDXW = $clog2(MAX_ITEMS);
  localparam int CNTW = $clog2(MAX_ITEMS + 1);
  localparam int PW   = 2 * CNTW;
  localparam int RW   = (PW > COUNT_W + 1) ? PW : COUNT_W + 1;
  localparam int SW   = (VALUE_BITS + 2 > TARGET_W) ? VALUE_BITS + 2 : TARGET_W;

  tscm_state_e state_q, state_d;

  logic [TARGET_W-1:0]   target_q;
  logic [CNTW-1:0]       count_q, count_d;
  logic                  ovf_q, ovf_d;
  logic [IDXW-1:0]       idx_q, idx_d, a_q, a_d, lo_q, lo_d, hi_q, hi_d;
  logic [VALUE_BITS-1:0] va_q, va_d, vl_q, vl_d, vh_q, vh_d;
  logic [CNTW-1:0]       cl_q, cl_d, ch_q, ch_d, ma_q, ma_d, mb_q, mb_d;
  logic                  half_q, half_d, aft_q, aft_d;
  logic [RW-1:0]         p_q, p_d;
  logic [COUNT_W-1:0]    total_q, total_d;
  logic                  done_q, done_d;
  logic [COUNT_W-1:0]    res_q, res_d;
  logic                  res_ovf_q, res_ovf_d;

  logic [VALUE_BITS-1:0] mem [MAX_ITEMS];
  logic [IDXW-1:0]       ra, rb;
  logic [VALUE_BITS-1:0] da_q, db_q;
  logic                  we;
  logic [VALUE_BITS-1:0] head;
  tscm_ctrl_t            ctrl;

  logic                  accept;
  logic [SW-1:0]         sum, tgt;
  logic [PW-1:0]         prod;
  logic [COUNT_W:0]      acc;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign sum    = SW'(va_q) + SW'(da_q) + SW'(db_q);
  assign tgt    = SW'(target_q);
  assign prod   = PW'(ma_q) * PW'(mb_q);
  assign acc    = (COUNT_W + 1)'(total_q) + (COUNT_W + 1)'(p_q);

  tscm_chain #(.MAX_ITEMS(MAX_ITEMS), .VALUE_BITS(VALUE_BITS)) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .x_i    (value_i),
    .ctrl_i (ctrl),
    .head_o (head)
  );

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[idx_q] <= head;
    end
    da_q <= mem[ra];
    db_q <= mem[rb];
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    idx_d     = idx_q;
    a_d       = a_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    va_d      = va_q;
    vl_d      = vl_q;
    vh_d      = vh_q;
    cl_d      = cl_q;
    ch_d      = ch_q;
    ma_d      = ma_q;
    mb_d      = mb_q;
    half_d    = half_q;
    aft_d     = aft_q;
    p_d       = p_q;
    total_d   = total_q;
    done_d    = 1'b0;
    res_d     = res_q;
    res_ovf_d = res_ovf_q;
    ctrl      = '0;
    we        = 1'b0;
    ra        = a_q;
    rb        = hi_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (count_q < CNTW'(MAX_ITEMS)) begin
            ctrl.ins = 1'b1;
            count_d  = count_q + CNTW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            idx_d   = '0;
            total_d = '0;
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        we       = 1'b1;
        ctrl.shf = 1'b1;
        idx_d    = idx_q + IDXW'(1);
        if (idx_q == IDXW'(count_q - CNTW'(1))) begin
          a_d  = '0;
          lo_d = IDXW'(1);
          hi_d = IDXW'(count_q - CNTW'(1));
          if (count_q < CNTW'(3)) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_A_RD;
          end
        end
      end
      ST_A_RD: begin
        ra      = a_q;
        state_d = ST_A_WT;
      end
      ST_A_WT: begin
        va_d    = da_q;
        state_d = ST_P_RD;
      end
      ST_P_RD: begin
        ra = lo_q;
        rb = hi_q;
        if (lo_q < hi_q) begin
          state_d = ST_P_EV;
        end else begin
          state_d = ST_NEXT_A;
        end
      end
      ST_P_EV: begin
        if (sum < tgt) begin
          lo_d    = lo_q + IDXW'(1);
          state_d = ST_P_RD;
        end else if (sum > tgt) begin
          hi_d    = hi_q - IDXW'(1);
          state_d = ST_P_RD;
        end else if (da_q == db_q) begin
          ma_d    = CNTW'(hi_q) - CNTW'(lo_q) + CNTW'(1);
          mb_d    = CNTW'(hi_q) - CNTW'(lo_q);
          half_d  = 1'b1;
          aft_d   = 1'b1;
          state_d = ST_MUL;
        end else begin
          vl_d    = da_q;
          vh_d    = db_q;
          cl_d    = CNTW'(1);
          ch_d    = CNTW'(1);
          state_d = ST_RL_RD;
        end
      end
      ST_RL_RD: begin
        ra      = lo_q + IDXW'(1);
        state_d = ST_RL_EV;
      end
      ST_RL_EV: begin
        if (da_q == vl_q) begin
          lo_d    = lo_q + IDXW'(1);
          cl_d    = cl_q + CNTW'(1);
          state_d = ST_RL_RD;
        end else begin
          state_d = ST_RH_RD;
        end
      end
      ST_RH_RD: begin
        rb      = hi_q - IDXW'(1);
        state_d = ST_RH_EV;
      end
      ST_RH_EV: begin
        if (db_q == vh_q) begin
          hi_d    = hi_q - IDXW'(1);
          ch_d    = ch_q + CNTW'(1);
          state_d = ST_RH_RD;
        end else begin
          ma_d    = cl_q;
          mb_d    = ch_q;
          half_d  = 1'b0;
          aft_d   = 1'b0;
          lo_d    = lo_q + IDXW'(1);
          hi_d    = hi_q - IDXW'(1);
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        p_d     = half_q ? RW'(prod >> 1) : RW'(prod);
        state_d = ST_RED;
      end
      ST_RED: begin
        if (p_q >= RW'(COUNT_MOD)) begin
          p_d = p_q - RW'(COUNT_MOD);
        end else begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (acc >= (COUNT_W + 1)'(COUNT_MOD)) begin
          total_d = COUNT_W'(acc - (COUNT_W + 1)'(COUNT_MOD));
        end else begin
          total_d = COUNT_W'(acc);
        end
        state_d = aft_q ? ST_NEXT_A : ST_P_RD;
      end
      ST_NEXT_A: begin
        if ((CNTW + 1)'(a_q) + (CNTW + 1)'(3) < (CNTW + 1)'(count_q)) begin
          a_d     = a_q + IDXW'(1);
          lo_d    = a_q + IDXW'(2);
          hi_d    = IDXW'(count_q - CNTW'(1));
          state_d = ST_A_RD;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        done_d    = 1'b1;
        res_d     = total_q;
        res_ovf_d = ovf_q;
        count_d   = '0;
        ovf_d     = 1'b0;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      target_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      done_q  <= done_d;
      if (target_sum_we_i) begin
        target_q <= target_sum_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    a_q       <= a_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    va_q      <= va_d;
    vl_q      <= vl_d;
    vh_q      <= vh_d;
    cl_q      <= cl_d;
    ch_q      <= ch_d;
    ma_q      <= ma_d;
    mb_q      <= mb_d;
    half_q    <= half_d;
    aft_q     <= aft_d;
    p_q       <= p_d;
    total_q   <= total_d;
    res_q     <= res_d;
    res_ovf_q <= res_ovf_d;
  end

  assign done_o         = done_q;
  assign triple_count_o = res_q;
  assign overflow_o     = res_ovf_q;

endmodule

`default_nettype wire

// File: design/tscm_cell.sv
// ----------------------------------------------------------------------------
// tscm_cell
// one cell of the sorting chain: holds one value, inserts or shifts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tscm_cell
  import tscm_pkg::*;
#(
  parameter int VALUE_BITS = TSCM_VALUE_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [VALUE_BITS-1:0] x_i,
  input  wire tscm_ctrl_t            ctrl_i,
  input  wire logic                  prv_lt_i,
  input  wire logic [VALUE_BITS-1:0] prv_val_i,
  input  wire logic                  prv_vld_i,
  input  wire logic [VALUE_BITS-1:0] nxt_val_i,
  input  wire logic                  nxt_vld_i,
  output logic [VALUE_BITS-1:0]      val_o,
  output logic                       vld_o,
  output logic                       lt_o
);

  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  vld_q, vld_d;

  assign lt_o  = !vld_q || (x_i < val_q);
  assign val_o = val_q;
  assign vld_o = vld_q;

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctrl_i.ins && lt_o) begin
      if (prv_lt_i) begin
        val_d = prv_val_i;
        vld_d = prv_vld_i;
      end else begin
        val_d = x_i;
        vld_d = 1'b1;
      end
    end else if (ctrl_i.shf) begin
      val_d = nxt_val_i;
      vld_d = nxt_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

// File: design/tscm_chain.sv
// ----------------------------------------------------------------------------
// tscm_chain
// row of sorting cells, ascending from the head, shifts out at the head
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tscm_chain
  import tscm_pkg::*;
#(
  parameter int MAX_ITEMS  = TSCM_MAX_ITEMS,
  parameter int VALUE_BITS = TSCM_VALUE_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [VALUE_BITS-1:0] x_i,
  input  wire tscm_ctrl_t            ctrl_i,
  output logic [VALUE_BITS-1:0]      head_o
);

  logic [VALUE_BITS-1:0] val [MAX_ITEMS];
  logic                  vld [MAX_ITEMS];
  logic                  lt  [MAX_ITEMS];

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                  p_lt, p_vld, n_vld;
    logic [VALUE_BITS-1:0] p_val, n_val;

    if (i == 0) begin : g_first
      assign p_lt  = 1'b0;
      assign p_val = '0;
      assign p_vld = 1'b0;
    end else begin : g_mid
      assign p_lt  = lt[i-1];
      assign p_val = val[i-1];
      assign p_vld = vld[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_last
      assign n_val = '0;
      assign n_vld = 1'b0;
    end else begin : g_rest
      assign n_val = val[i+1];
      assign n_vld = vld[i+1];
    end

    tscm_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .x_i       (x_i),
      .ctrl_i    (ctrl_i),
      .prv_lt_i  (p_lt),
      .prv_val_i (p_val),
      .prv_vld_i (p_vld),
      .nxt_val_i (n_val),
      .nxt_vld_i (n_vld),
      .val_o     (val[i]),
      .vld_o     (vld[i]),
      .lt_o      (lt[i])
    );
  end

  assign head_o = val[0];

endmodule

`default_nettype wire

// File: design/tscm_checker.sv
// ----------------------------------------------------------------------------
// tscm_checker
// port-level checks of the three-sum counter, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tscm_checker
  import tscm_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done_o,
  input wire logic [COUNT_W-1:0] triple_count_o
);

  `TSCM_ASSERT(a_done_after_busy, done_o, $past(busy))
  `TSCM_ASSERT(a_count_in_range, done_o, triple_count_o < COUNT_MOD)
  `TSCM_ASSERT(a_busy_on_start, $rose(busy), $past(start))
  `TSCM_ASSERT_NXT(a_single_done, done_o, !done_o)

endmodule

bind three_sum_count_with_multiplicity_core tscm_checker u_tscm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .triple_count_o (triple_count_o)
);

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-sum triple counter. Data sets are sent
// value by value, with random gaps between transactions. Expected counts come
// from a value histogram and closed-form combinations, taken modulo 1e9+7.
// Results are checked in order against them. The target register is
// rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class triple_scoreboard;
  localparam longint unsigned PRIME = 64'd1000000007;
  int unsigned hist [256];
  int unsigned n_stored;
  bit dropped;
  int unsigned target;
  logic [29:0] count_q [$];
  bit ovf_q [$];
  int unsigned errors;

  function new();
    clear_set();
    target = 0;
    errors = 0;
  endfunction

  function void clear_set();
    foreach (hist[i]) hist[i] = 0;
    n_stored = 0;
    dropped = 0;
  endfunction

  function longint unsigned choose2(longint unsigned m);
    return (m < 2) ? 0 : m * (m - 1) / 2;
  endfunction

  function longint unsigned choose3(longint unsigned m);
    return (m < 3) ? 0 : m * (m - 1) * (m - 2) / 6;
  endfunction

  function logic [29:0] count_triples();
    longint unsigned total;
    int z;
    total = 0;
    for (int x = 0; x < 256; x++) begin
      for (int y = x; y < 256; y++) begin
        z = int'(target) - x - y;
        if (z < y || z > 255) continue;
        if (x == y && y == z) total += choose3(hist[x]);
        else if (x == y) total += choose2(hist[x]) * hist[z];
        else if (y == z) total += hist[x] * choose2(hist[y]);
        else total += longint'(hist[x]) * hist[y] * hist[z];
        total = total % PRIME;
      end
    end
    return total[29:0];
  endfunction

  function void note_value(logic [7:0] v, bit is_last);
    if (n_stored < 1024) begin
      hist[v]++;
      n_stored++;
    end else begin
      dropped = 1;
    end
    if (is_last) begin
      count_q = {count_q, count_triples()};
      ovf_q = {ovf_q, dropped};
      clear_set();
    end
  endfunction

  function void check_result(logic [29:0] cnt, logic ovf);
    logic [29:0] exp_cnt;
    bit exp_ovf;
    if (count_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: count %0d overflow %0d", cnt, ovf);
      return;
    end
    exp_cnt = count_q.pop_front();
    exp_ovf = ovf_q.pop_front();
    if (cnt !== exp_cnt || ovf !== exp_ovf) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: count exp %0d got %0d, overflow exp %0d got %0d",
                 exp_cnt, cnt, exp_ovf, ovf);
    end
  endfunction
endclass

module testbench;
  import tscm_pkg::*;

  localparam int WATCHDOG_LIMIT = 12000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [7:0] value_i = '0;
  logic last_i = 1'b0;
  logic target_sum_we_i = 1'b0;
  logic [TARGET_W-1:0] target_sum_i = '0;
  logic done_o;
  logic [COUNT_W-1:0] triple_count_o;
  logic overflow_o;

  triple_scoreboard sb = new();
  int unsigned idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  three_sum_count_with_multiplicity_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .value_i        (value_i),
    .last_i         (last_i),
    .target_sum_we_i(target_sum_we_i),
    .target_sum_i   (target_sum_i),
    .done_o         (done_o),
    .triple_count_o (triple_count_o),
    .overflow_o     (overflow_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(triple_count_o, overflow_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic gap();
    int unsigned r, len;
    r = $urandom_range(0, 99);
    if (r < 60) len = 0;
    else if (r < 95) len = $urandom_range(1, 3);
    else len = $urandom_range(10, 40);
    if (len != 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  task automatic send_value(logic [7:0] v, bit is_last, bit no_gap = 0);
    start <= 1'b1;
    value_i <= v;
    last_i <= is_last;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_value(v, is_last);
    if (!no_gap) gap();
  endtask

  task automatic write_target(int unsigned t);
    start <= 1'b0;
    while (sb.count_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    target_sum_we_i <= 1'b1;
    target_sum_i <= t[TARGET_W-1:0];
    @(posedge clk_i);
    target_sum_we_i <= 1'b0;
    sb.target = t;
  endtask

  task automatic send_set(logic [7:0] vals [$]);
    foreach (vals[i]) send_value(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_uniform(logic [7:0] v, int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_value(v, i == n - 1, 1);
  endtask

  task automatic random_phase(int unsigned t, int unsigned items);
    int unsigned sent, n, c, lo, hi;
    logic [7:0] vals [$];
    write_target(t);
    c = t / 3;
    lo = (c > 4) ? c - 4 : 0;
    hi = (c + 4 > 255) ? 255 : c + 4;
    sent = 0;
    while (sent < items) begin
      vals.delete();
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) < 7) vals = {vals, 8'($urandom_range(lo, hi))};
        else vals = {vals, 8'($urandom_range(0, 255))};
      end
      send_set(vals);
      sent += n;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: target at its reset value of zero
    send_set('{8'd0, 8'd0, 8'd0});
    send_set('{8'd0});
    send_set('{8'd0, 8'd0});
    send_set('{8'd0, 8'd0, 8'd0, 8'd0});
    write_target(765);
    send_set('{8'd255, 8'd255, 8'd255, 8'd255, 8'd254});
    write_target(255);
    send_set('{8'haa, 8'h55, 8'd0, 8'd255, 8'd1, 8'd254});
    write_target(6);
    send_set('{8'd1, 8'd2, 8'd3, 8'd3, 8'd2, 8'd1, 8'd2});
    // store full, last dropped
    write_target(21);
    send_uniform(8'd7, 1025);

    random_phase(0, 150);
    random_phase(765, 150);
    random_phase(300, 150);
    for (int p = 0; p < 2; p++) random_phase($urandom_range(0, 765), 150);
    random_phase(765, 100);

    start <= 1'b0;
    while (sb.count_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+design
design/tscm_pkg.sv
design/tscm_cell.sv
design/tscm_chain.sv
design/three_sum_count_with_multiplicity_core.sv
design/tscm_checker.sv
bench/testbench.sv
